// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while reset is released.
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ppp_pkg.sv
// Shared constants, types and tables of the point projection block.
package ppp_pkg;

  // Largest frame dimension that the bound compare honors.
  localparam int MAX_DIM = 4096;

  localparam int POS_W   = 24;
  localparam int CLS_W   = 2;
  localparam int CFG_W   = 13;
  localparam int COORD_W = 16;
  localparam int BGR_W   = 24;
  localparam int CFG_IDX_W = 1;

  localparam int COEF_W  = 32;
  localparam int PROD_W  = COEF_W + POS_W;
  localparam int ACC_W   = 59;
  localparam int MAG_W   = ACC_W - 1;

  // Quotient width in Q.4 and the pre-shift that keeps the remainder below the divisor.
  localparam int Q_W     = $clog2(MAX_DIM * 16);
  localparam int PRE_SH  = Q_W - 4;
  localparam int CMP_W   = MAG_W + PRE_SH;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int BOUND_W = DIM_W + 4;

  // Request to result strobe, in clock cycles.
  localparam int LATENCY = Q_W + 7;

  localparam logic [CFG_W-1:0] FRAME_W_RESET = 13'd1280;
  localparam logic [CFG_W-1:0] FRAME_H_RESET = 13'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Projection matrix K*E in signed Q12.20.
  localparam logic signed [COEF_W-1:0] PROJ_M [3][4] = '{
    '{ 32'sd664840386, -32'sd556268542, -32'sd7164073,   32'sd1319517233},
    '{-32'sd2489524,    32'sd8501163,   -32'sd558538733, 32'sd502000070},
    '{ 32'sd1048567,    32'sd3700,       32'sd2131,      32'sd2008448}
  };

  // Packed BGR per color class: red, blue, yellow, other.
  localparam logic [BGR_W-1:0] COLOR_LUT [4] = '{
    24'h0000FF, 24'hFF0000, 24'h00FFFF, 24'hFFFFFF
  };

  // Side information that travels with a point through the divider.
  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] cls;
  } tag_t;

endpackage

// File: hw/rtl/ppp_mac.sv
// Matrix-vector product: one multiply stage and one sum stage.
module ppp_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [ppp_pkg::POS_W-1:0]   in_x,
  input  logic signed [ppp_pkg::POS_W-1:0]   in_y,
  input  logic signed [ppp_pkg::POS_W-1:0]   in_z,
  input  logic [ppp_pkg::CLS_W-1:0]          in_cls,
  output logic                               out_valid,
  output logic signed [ppp_pkg::ACC_W-1:0]   out_acc [3],
  output logic [ppp_pkg::CLS_W-1:0]          out_cls
);
  import ppp_pkg::*;

  logic                       prod_vld_r;
  logic signed [PROD_W-1:0]   prod_r [3][3];
  logic [CLS_W-1:0]           prod_cls_r;
  logic                       sum_vld_r;
  logic signed [ACC_W-1:0]    sum_r [3];
  logic [CLS_W-1:0]           sum_cls_r;
  logic signed [POS_W-1:0]    pt [3];

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  // Nine products, one per entry of the first three matrix columns.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= in_valid;
    end
    prod_cls_r <= in_cls;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= PROD_W'(PROJ_M[i][j]) * PROD_W'(pt[j]);
      end
    end
  end

  // Row sums plus the translation column scaled by the homogeneous one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= prod_vld_r;
    end
    sum_cls_r <= prod_cls_r;
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1]) + ACC_W'(prod_r[i][2])
                + (ACC_W'(PROJ_M[i][3]) <<< 16);
    end
  end

  assign out_valid = sum_vld_r;
  assign out_acc   = sum_r;
  assign out_cls   = sum_cls_r;

endmodule

// File: hw/rtl/ppp_div.sv
// Two restoring dividers side by side, one quotient bit per pipeline stage.
module ppp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  ppp_pkg::tag_t                in_tag,
  input  logic [ppp_pkg::MAG_W-1:0]    in_num_u,
  input  logic [ppp_pkg::MAG_W-1:0]    in_num_v,
  input  logic [ppp_pkg::MAG_W-1:0]    in_den,
  output logic                         out_valid,
  output ppp_pkg::tag_t                out_tag,
  output logic [ppp_pkg::Q_W-1:0]      out_q_u,
  output logic [ppp_pkg::Q_W-1:0]      out_q_v
);
  import ppp_pkg::*;

  logic             vld_r   [0:Q_W];
  tag_t             tag_r   [0:Q_W];
  logic [MAG_W-1:0] den_r   [0:Q_W];
  logic [MAG_W-1:0] rem_u_r [0:Q_W];
  logic [MAG_W-1:0] rem_v_r [0:Q_W];
  logic [Q_W-1:0]   low_u_r [0:Q_W];
  logic [Q_W-1:0]   low_v_r [0:Q_W];
  logic [Q_W-1:0]   q_u_r   [0:Q_W];
  logic [Q_W-1:0]   q_v_r   [0:Q_W];

  logic [MAG_W-1:0] rem_u_nxt [Q_W];
  logic [MAG_W-1:0] rem_v_nxt [Q_W];
  logic             bit_u     [Q_W];
  logic             bit_v     [Q_W];

  // One trial subtraction per lane and stage.
  always_comb begin
    logic [MAG_W:0] trial_u;
    logic [MAG_W:0] trial_v;
    for (int k = 0; k < Q_W; k++) begin
      trial_u      = {rem_u_r[k], low_u_r[k][Q_W-1]};
      trial_v      = {rem_v_r[k], low_v_r[k][Q_W-1]};
      bit_u[k]     = trial_u >= {1'b0, den_r[k]};
      bit_v[k]     = trial_v >= {1'b0, den_r[k]};
      rem_u_nxt[k] = bit_u[k] ? MAG_W'(trial_u - {1'b0, den_r[k]}) : trial_u[MAG_W-1:0];
      rem_v_nxt[k] = bit_v[k] ? MAG_W'(trial_v - {1'b0, den_r[k]}) : trial_v[MAG_W-1:0];
    end
  end

  // Load stage, then one stage per quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q_W; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < Q_W; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    tag_r[0]   <= in_tag;
    den_r[0]   <= in_den;
    rem_u_r[0] <= MAG_W'(in_num_u >> PRE_SH);
    rem_v_r[0] <= MAG_W'(in_num_v >> PRE_SH);
    low_u_r[0] <= {in_num_u[PRE_SH-1:0], 4'b0000};
    low_v_r[0] <= {in_num_v[PRE_SH-1:0], 4'b0000};
    q_u_r[0]   <= '0;
    q_v_r[0]   <= '0;
    for (int k = 0; k < Q_W; k++) begin
      tag_r[k+1]   <= tag_r[k];
      den_r[k+1]   <= den_r[k];
      rem_u_r[k+1] <= rem_u_nxt[k];
      rem_v_r[k+1] <= rem_v_nxt[k];
      low_u_r[k+1] <= low_u_r[k] << 1;
      low_v_r[k+1] <= low_v_r[k] << 1;
      q_u_r[k+1]   <= {q_u_r[k][Q_W-2:0], bit_u[k]};
      q_v_r[k+1]   <= {q_v_r[k][Q_W-2:0], bit_v[k]};
    end
  end

  assign out_valid = vld_r[Q_W];
  assign out_tag   = tag_r[Q_W];
  assign out_q_u   = q_u_r[Q_W];
  assign out_q_v   = q_v_r[Q_W];

endmodule

// File: hw/rtl/pinhole_point_projection.sv
// Top level of the pinhole point projection pipeline.
// A request (in_pos_x, in_pos_y, in_pos_z in signed Q8.16, in_color_class) is
// taken at each rising edge where start is high and busy is low. busy is always
// low: the pipeline takes one request in every cycle.
// The point is multiplied by the fixed 3x4 projection matrix, the result is
// normalized to a non-negative divisor, and u and v are divided by it in two
// restoring dividers that produce one quotient bit per stage.
// A point that lands inside the frame gives one result, shown for one cycle
// with out_valid high; points outside the frame or with a zero divisor give none.
// The pipeline holds the 16 quotient-bit stages of the divider plus seven stages for
// input, products, sums, sign handling, range check, divider load and output.
// Throughput is one point per cycle.
// The user is to write the frame registers through cfg_we, cfg_addr and cfg_wdata
// only while no request is in flight; the block does not enforce it. Reset sets
// them to 1280 and 360. Reset empties the pipeline; requests in flight are dropped.
// The receiver cannot stall, so results are never held.
module pinhole_point_projection (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ppp_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ppp_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ppp_pkg::POS_W-1:0]  in_pos_z,
  input  logic [ppp_pkg::CLS_W-1:0]         in_color_class,
  output logic                              out_valid,
  output logic [ppp_pkg::COORD_W-1:0]       out_u_q4,
  output logic [ppp_pkg::COORD_W-1:0]       out_v_q4,
  output logic [ppp_pkg::BGR_W-1:0]         out_color_bgr,
  input  logic                              cfg_we,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ppp_pkg::CFG_W-1:0]         cfg_wdata
);
  import ppp_pkg::*;

  logic [CFG_W-1:0]        frame_w_r;
  logic [CFG_W-1:0]        frame_h_r;

  logic                    in_vld_r;
  logic signed [POS_W-1:0] x_r, y_r, z_r;
  logic [CLS_W-1:0]        cls_r;

  logic                    mac_vld;
  logic signed [ACC_W-1:0] mac_acc [3];
  logic [CLS_W-1:0]        mac_cls;

  logic                    neg_vld_r;
  logic signed [ACC_W-1:0] num_u_r, num_v_r, den_r;
  logic [CLS_W-1:0]        neg_cls_r;

  logic                    chk_vld_r;
  tag_t                    chk_tag_r;
  logic [MAG_W-1:0]        chk_u_r, chk_v_r, chk_d_r;

  logic                    div_vld;
  tag_t                    div_tag;
  logic [Q_W-1:0]          div_q_u, div_q_v;

  logic [DIM_W-1:0]        eff_w, eff_h;
  logic [BOUND_W-1:0]      bound_u, bound_v;
  logic                    in_frame;

  logic                    out_vld_r;
  logic [COORD_W-1:0]      u_r, v_r;
  logic [BGR_W-1:0]        bgr_r;

  // Every cycle can take a request.
  assign busy = 1'b0;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_W_RESET;
      frame_h_r <= FRAME_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    x_r   <= in_pos_x;
    y_r   <= in_pos_y;
    z_r   <= in_pos_z;
    cls_r <= in_color_class;
  end

  ppp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .in_x      (x_r),
    .in_y      (y_r),
    .in_z      (z_r),
    .in_cls    (cls_r),
    .out_valid (mac_vld),
    .out_acc   (mac_acc),
    .out_cls   (mac_cls)
  );

  // Make the divisor non-negative by negating all three components together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_vld_r <= 1'b0;
    end else begin
      neg_vld_r <= mac_vld;
    end
    neg_cls_r <= mac_cls;
    if (mac_acc[2] < 0) begin
      num_u_r <= -mac_acc[0];
      num_v_r <= -mac_acc[1];
      den_r   <= -mac_acc[2];
    end else begin
      num_u_r <= mac_acc[0];
      num_v_r <= mac_acc[1];
      den_r   <= mac_acc[2];
    end
  end

  // Reject a zero divisor, a negative numerator, or a quotient beyond the divider range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= neg_vld_r;
    end
    chk_tag_r.cls <= neg_cls_r;
    chk_tag_r.ok  <= (den_r != '0) && !num_u_r[ACC_W-1] && !num_v_r[ACC_W-1]
                  && (CMP_W'(num_u_r[MAG_W-1:0]) < (CMP_W'(den_r[MAG_W-1:0]) << PRE_SH))
                  && (CMP_W'(num_v_r[MAG_W-1:0]) < (CMP_W'(den_r[MAG_W-1:0]) << PRE_SH));
    chk_u_r <= num_u_r[MAG_W-1:0];
    chk_v_r <= num_v_r[MAG_W-1:0];
    chk_d_r <= den_r[MAG_W-1:0];
  end

  ppp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chk_vld_r),
    .in_tag    (chk_tag_r),
    .in_num_u  (chk_u_r),
    .in_num_v  (chk_v_r),
    .in_den    (chk_d_r),
    .out_valid (div_vld),
    .out_tag   (div_tag),
    .out_q_u   (div_q_u),
    .out_q_v   (div_q_v)
  );

  // Frame bounds, clamped to the largest supported dimension, in Q.4.
  assign eff_w   = (int'(frame_w_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(frame_w_r);
  assign eff_h   = (int'(frame_h_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(frame_h_r);
  assign bound_u = {eff_w, 4'b0000};
  assign bound_v = {eff_h, 4'b0000};
  assign in_frame = (BOUND_W'(div_q_u) < bound_u) && (BOUND_W'(div_q_v) < bound_v);

  // Output register; coordinates saturate at the port width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= div_vld && div_tag.ok && in_frame;
    end
    u_r   <= (32'(div_q_u) > 32'hFFFF) ? '1 : COORD_W'(div_q_u);
    v_r   <= (32'(div_q_v) > 32'hFFFF) ? '1 : COORD_W'(div_q_v);
    bgr_r <= COLOR_LUT[div_tag.cls];
  end

  assign out_valid     = out_vld_r;
  assign out_u_q4      = u_r;
  assign out_v_q4      = v_r;
  assign out_color_bgr = bgr_r;

endmodule

// File: hw/rtl/ppp_chk.sv
// Port-level checker of the point projection block and its bind.
`include "assert_macros.svh"

module ppp_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [ppp_pkg::BGR_W-1:0]         out_color_bgr
);
  import ppp_pkg::*;

  // The pipeline never refuses a request.
  `PPP_ASSERT(a_never_busy, !busy, "busy raised")

  // A result must trace back to an accepted request.
  `PPP_ASSERT(a_result_has_request, out_valid |-> $past(start && !busy, LATENCY), "result without request")

  // A result color is one of the four class colors.
  `PPP_ASSERT(a_color_code, out_valid |-> (out_color_bgr == COLOR_LUT[0] || out_color_bgr == COLOR_LUT[1] || out_color_bgr == COLOR_LUT[2] || out_color_bgr == COLOR_LUT[3]), "bad color")

  // Reset clears the result strobe.
  `PPP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind pinhole_point_projection ppp_chk u_ppp_chk (.*);
